FILE: sv/lsh_pkg.sv
// ----------------------------------------------------------------------------
// Laplacian sharpen package
// Shared sizes, register indexes and reset values of the 3x3 cross-kernel
// sharpening block.
// ----------------------------------------------------------------------------
`default_nettype none

package lsh_pkg;

   // frame limits
   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_CHANNELS = 4;
   localparam int MAX_HEIGHT   = 4096;
   localparam int LINE_DEPTH   = MAX_WIDTH * MAX_CHANNELS;

   // derived widths
   localparam int ADDR_W = $clog2(LINE_DEPTH);
   localparam int PX_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   // payload
   localparam int SAMPLE_W    = 8;
   localparam int SAMPLE_MAX  = (1 << SAMPLE_W) - 1;
   localparam int CENTER_GAIN = 5;
   // 5*255 and -4*255 both fit a signed sample plus four bits
   localparam int ACC_W       = SAMPLE_W + 4;

   // control and status registers
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int CHAN_REG_W   = 3;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_IDX_W    = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = CSR_IDX_W'(2);

   localparam int WIDTH_RESET   = 640;
   localparam int HEIGHT_RESET  = 480;
   localparam int CHANNEL_RESET = 3;
   localparam int MIN_SIZE      = 3;

endpackage : lsh_pkg

`default_nettype wire

FILE: sv/lsh_intf.sv
// ----------------------------------------------------------------------------
// Laplacian sharpen channels
// Valid/ready channels carrying source samples in and sharpened samples out.
// ----------------------------------------------------------------------------
`default_nettype none

// source image samples
interface lsh_req_if;
   logic                         valid;
   logic                         ready;
   logic [lsh_pkg::SAMPLE_W-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface : lsh_req_if

// sharpened samples
interface lsh_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [lsh_pkg::SAMPLE_W-1:0] sample_out;
   logic                         last_in_run;
   logic                         end_of_frame;

   modport source (output valid, output sample_out, output last_in_run,
                   output end_of_frame, input ready);
   modport sink   (input valid, input sample_out, input last_in_run,
                   input end_of_frame, output ready);
endinterface : lsh_rsp_if

`default_nettype wire

FILE: sv/laplacian_sharpen_3x3.sv
// ----------------------------------------------------------------------------
// Laplacian sharpen 3x3
// Streaming cross-kernel sharpen of an interleaved 8-bit image using two
// line memories.
// ----------------------------------------------------------------------------
// Samples arrive one channel byte per item in raster order. Each sample of
// row r (r >= 1) gives the sharpened sample at the same position of row r-1:
// 5*centre - up - down - left - right, clamped to 0..255, zero on the frame
// border. Row 0 gives no result; each sample of the last row gives two: the
// row above, then its own zero border sample, the last of them flagged
// end_of_frame at the bottom-right corner. One item is taken per clock while
// each item gives at most one result and the output is not stalled; on the
// last row the next item waits for each second result in the output register.
// Results pass the read stage, then the output register. The line memories are
// read when an item is accepted; the older is written back from the read stage;
// they need no clearing after reset. A register write restarts the frame at
// row 0, column 0; the user must write only while idle; the block does not check.
`default_nettype none

module laplacian_sharpen_3x3 (
   input  wire logic                              clock,
   input  wire logic                              reset,
   lsh_req_if.sink                                req_bus,
   lsh_rsp_if.source                              rsp_bus,
   input  wire logic                              csr_we,
   input  wire logic [lsh_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [lsh_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int ADDR_W   = lsh_pkg::ADDR_W;
   localparam int PX_W     = lsh_pkg::PX_W;
   localparam int ROW_W    = lsh_pkg::ROW_W;
   localparam int CH_W     = lsh_pkg::CH_W;
   localparam int SAMPLE_W = lsh_pkg::SAMPLE_W;
   localparam int ACC_W    = lsh_pkg::ACC_W;

   // effective sizes, held minus one
   logic [PX_W-1:0]  w_m1_ff, w_m1_in;
   logic [ROW_W-1:0] h_m1_ff, h_m1_in;
   logic [CH_W-1:0]  c_m1_ff, c_m1_in;
   logic             restart;

   // stream position
   logic [ADDR_W-1:0] s_ff, s_in;
   logic [PX_W-1:0]   px_ff, px_in;
   logic [CH_W-1:0]   ch_ff, ch_in;
   logic [ROW_W-1:0]  row_ff, row_in;

   // read stage
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_has_main_ff;
   logic                s1_border_ff;
   logic                s1_has_last_ff;
   logic                s1_eof_ff;
   logic [SAMPLE_W-1:0] s1_down_ff;
   logic [ADDR_W-1:0]   s1_addr_ff;
   logic [SAMPLE_W-1:0] rd_center_ff;
   logic [SAMPLE_W-1:0] rd_right_ff;
   logic [SAMPLE_W-1:0] rd_up_ff;

   // output register and pending border result
   logic                out_valid_ff, out_valid_in;
   logic [SAMPLE_W-1:0] out_value_ff, out_value_in;
   logic                out_last_ff, out_last_in;
   logic                out_eof_ff, out_eof_in;
   logic                sec_valid_ff, sec_valid_in;
   logic                sec_eof_ff, sec_eof_in;

   // memories and recent centre samples
   logic [SAMPLE_W-1:0] newer_mem [lsh_pkg::LINE_DEPTH];
   logic [SAMPLE_W-1:0] older_mem [lsh_pkg::LINE_DEPTH];
   logic [SAMPLE_W-1:0] win_ff [lsh_pkg::MAX_CHANNELS];

   logic                accept;
   logic                slot_free;
   logic                s1_adv;
   logic                row_end;
   logic [ADDR_W-1:0]   right_addr;
   logic [ACC_W-1:0]    acc;
   logic [SAMPLE_W-1:0] main_value;

   // handshake
   assign slot_free = !sec_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign s1_adv    = s1_valid_ff && (!s1_has_main_ff || slot_free);
   assign req_bus.ready = !s1_valid_ff || s1_adv;
   assign accept    = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.sample_out   = out_value_ff;
   assign rsp_bus.last_in_run  = out_last_ff;
   assign rsp_bus.end_of_frame = out_eof_ff;

   // register writes, clamped to the supported range
   always_comb begin
      w_m1_in = w_m1_ff;
      h_m1_in = h_m1_ff;
      c_m1_in = c_m1_ff;
      restart = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            lsh_pkg::CSR_IMAGE_WIDTH: begin
               restart = 1'b1;
               if (csr_wdata[lsh_pkg::WIDTH_REG_W-1:0] < lsh_pkg::MIN_SIZE) begin
                  w_m1_in = PX_W'(lsh_pkg::MIN_SIZE - 1);
               end else if (csr_wdata[lsh_pkg::WIDTH_REG_W-1:0] > lsh_pkg::MAX_WIDTH) begin
                  w_m1_in = PX_W'(lsh_pkg::MAX_WIDTH - 1);
               end else begin
                  w_m1_in = PX_W'(csr_wdata[lsh_pkg::WIDTH_REG_W-1:0] - 1'b1);
               end
            end
            lsh_pkg::CSR_IMAGE_HEIGHT: begin
               restart = 1'b1;
               if (csr_wdata[lsh_pkg::HEIGHT_REG_W-1:0] < lsh_pkg::MIN_SIZE) begin
                  h_m1_in = ROW_W'(lsh_pkg::MIN_SIZE - 1);
               end else if (csr_wdata[lsh_pkg::HEIGHT_REG_W-1:0] > lsh_pkg::MAX_HEIGHT) begin
                  h_m1_in = ROW_W'(lsh_pkg::MAX_HEIGHT - 1);
               end else begin
                  h_m1_in = ROW_W'(csr_wdata[lsh_pkg::HEIGHT_REG_W-1:0] - 1'b1);
               end
            end
            lsh_pkg::CSR_CHANNEL_COUNT: begin
               restart = 1'b1;
               if (csr_wdata[lsh_pkg::CHAN_REG_W-1:0] == '0) begin
                  c_m1_in = '0;
               end else if (csr_wdata[lsh_pkg::CHAN_REG_W-1:0] > lsh_pkg::MAX_CHANNELS) begin
                  c_m1_in = CH_W'(lsh_pkg::MAX_CHANNELS - 1);
               end else begin
                  c_m1_in = CH_W'(csr_wdata[lsh_pkg::CHAN_REG_W-1:0] - 1'b1);
               end
            end
            default: begin
               // unused index: ignored
               restart = 1'b0;
            end
         endcase
      end
   end

   // position counters: channel, pixel, sample address, row
   assign row_end = (ch_ff == c_m1_ff) && (px_ff == w_m1_ff);

   always_comb begin
      s_in   = s_ff;
      px_in  = px_ff;
      ch_in  = ch_ff;
      row_in = row_ff;
      if (restart) begin
         s_in   = '0;
         px_in  = '0;
         ch_in  = '0;
         row_in = '0;
      end else if (accept) begin
         if (row_end) begin
            s_in  = '0;
            px_in = '0;
            ch_in = '0;
            row_in = (row_ff == h_m1_ff) ? '0 : row_ff + 1'b1;
         end else begin
            s_in = s_ff + 1'b1;
            if (ch_ff == c_m1_ff) begin
               ch_in = '0;
               px_in = px_ff + 1'b1;
            end else begin
               ch_in = ch_ff + 1'b1;
            end
         end
      end
   end

   assign right_addr = s_ff + ADDR_W'(c_m1_ff) + 1'b1;

   // newer line: centre and right neighbour read, incoming sample written
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_center_ff     <= newer_mem[s_ff];
         rd_right_ff      <= newer_mem[right_addr];
         newer_mem[s_ff]  <= req_bus.sample_in;
      end
   end

   // older line: up neighbour read, centre written back from the read stage
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_up_ff <= older_mem[s_ff];
      end
      if (s1_adv) begin
         older_mem[s1_addr_ff] <= rd_center_ff;
      end
   end

   // left neighbour: centre of the same channel one pixel back
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         win_ff[0] <= rd_center_ff;
         for (int i = 1; i < lsh_pkg::MAX_CHANNELS; i++) begin
            win_ff[i] <= win_ff[i-1];
         end
      end
   end

   // kernel and clamp
   always_comb begin
      acc = ACC_W'(rd_center_ff) * ACC_W'(lsh_pkg::CENTER_GAIN)
          - ACC_W'(rd_up_ff) - ACC_W'(s1_down_ff)
          - ACC_W'(win_ff[c_m1_ff]) - ACC_W'(rd_right_ff);
      if (s1_border_ff || acc[ACC_W-1]) begin
         main_value = '0;
      end else if (acc[ACC_W-2:SAMPLE_W] != '0) begin
         main_value = SAMPLE_W'(lsh_pkg::SAMPLE_MAX);
      end else begin
         main_value = acc[SAMPLE_W-1:0];
      end
   end

   // read stage occupancy and per-item flags
   assign s1_valid_in = accept || (s1_valid_ff && !s1_adv);

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_has_main_ff <= (row_ff != '0);
         s1_border_ff   <= (row_ff == ROW_W'(1)) || (px_ff == '0) || (px_ff == w_m1_ff);
         s1_has_last_ff <= (row_ff == h_m1_ff);
         s1_eof_ff      <= (row_ff == h_m1_ff) && row_end;
         s1_down_ff     <= req_bus.sample_in;
         s1_addr_ff     <= s_ff;
      end
   end

   // output register; the border result of the last row waits behind it
   always_comb begin
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      out_eof_in   = out_eof_ff;
      sec_valid_in = sec_valid_ff;
      sec_eof_in   = sec_eof_ff;
      if (s1_adv && s1_has_main_ff) begin
         out_valid_in = 1'b1;
         out_value_in = main_value;
         out_last_in  = !s1_has_last_ff;
         out_eof_in   = 1'b0;
         sec_valid_in = s1_has_last_ff;
         sec_eof_in   = s1_eof_ff;
      end else if (out_valid_ff && rsp_bus.ready) begin
         if (sec_valid_ff) begin
            out_value_in = '0;
            out_last_in  = 1'b1;
            out_eof_in   = sec_eof_ff;
            sec_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         w_m1_ff      <= PX_W'(lsh_pkg::WIDTH_RESET - 1);
         h_m1_ff      <= ROW_W'(lsh_pkg::HEIGHT_RESET - 1);
         c_m1_ff      <= CH_W'(lsh_pkg::CHANNEL_RESET - 1);
         s_ff         <= '0;
         px_ff        <= '0;
         ch_ff        <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         sec_valid_ff <= 1'b0;
      end else begin
         w_m1_ff      <= w_m1_in;
         h_m1_ff      <= h_m1_in;
         c_m1_ff      <= c_m1_in;
         s_ff         <= s_in;
         px_ff        <= px_in;
         ch_ff        <= ch_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         sec_valid_ff <= sec_valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
      out_eof_ff   <= out_eof_in;
      sec_eof_ff   <= sec_eof_in;
   end

`ifndef SYNTHESIS
   // a pending border result is only held behind a shown result
   a_sec_behind_out: assert property (@(posedge clock) disable iff (reset)
      sec_valid_ff |-> out_valid_ff)
      else $error("border result pending without a shown result");

   // a non-final result is always followed by the zero border result
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready && !rsp_bus.last_in_run)
      |=> (rsp_bus.valid && rsp_bus.last_in_run && rsp_bus.sample_out == '0))
      else $error("second result of a last-row item missing");

   // frame end is the final, zero result of its item
   a_eof_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.end_of_frame)
      |-> (rsp_bus.last_in_run && rsp_bus.sample_out == '0))
      else $error("end of frame on a non-border result");

   // input is only held off by an occupied read stage
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (s1_valid_ff && s1_has_main_ff))
      else $error("input stalled with the read stage free");
`endif

endmodule : laplacian_sharpen_3x3

`default_nettype wire
